// File: src/semigraphic_sprite_or_macros.svh
// assertion macros used by the semigraphic sprite controller
`ifndef SEMIGRAPHIC_SPRITE_OR_MACROS_SVH
`define SEMIGRAPHIC_SPRITE_OR_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define SGSPR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgspr same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define SGSPR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgspr next-cycle check failed");

`endif

// File: src/sgspr_pkg.sv
// shared types, constants and character helpers for the semigraphic sprite block
`default_nettype none

package sgspr_pkg;

	// screen geometry
	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_CELLS   = 2048;
	localparam int CELLS_PER_BAND = 4;
	localparam int CELL_AW        = $clog2(SCREEN_CELLS);
	localparam int CHAR_W         = 8;

	// y / 3 as (y * 171) >> 9, exact for 8-bit y
	localparam int DIV3_RECIP = 171;
	localparam int DIV3_SHIFT = 9;
	localparam int YPROD_W    = 16;
	localparam int QUOT_W     = 7;
	localparam int BASE_W     = 14;

	// byte written to the first cell by a begin item
	localparam logic [CHAR_W-1:0] GFX_MODE_BYTE = 8'd132;
	localparam logic [CELL_AW-1:0] GFX_MODE_CELL = '0;

	typedef enum logic [1:0] {
		MODE_BEGIN   = 2'd0,
		MODE_BAND    = 2'd1,
		MODE_HOST_WR = 2'd2,
		MODE_HOST_RD = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BEGIN,
		ST_HOST_WR,
		ST_HOST_RD,
		ST_BAND_RD,
		ST_BAND_WR,
		ST_BAND_END,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic begin_wr;
		logic host_wr;
		logic host_rd;
		logic cell_rd;
		logic cell_wr;
		logic k_inc;
		logic band_adv;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic cell_active;
		logic k_last;
	} sts_t;

	// 2x3 block character to its 6-bit pattern, non-graphic bytes give zero
	function automatic logic [5:0] sg_decode(input logic [CHAR_W-1:0] c);
		logic [5:0] v;
		v = '0;
		if (!c[7] && c[5]) begin
			v = {c[6], c[4:0]};
		end
		return v;
	endfunction

	// 6-bit pattern back to the block character
	function automatic logic [CHAR_W-1:0] sg_encode(input logic [5:0] v);
		return {1'b0, v[5], 1'b1, v[4:0]};
	endfunction

	// pixel pair of column k in one bitmap byte: bit 7-2k to bit 0, bit 6-2k to bit 1
	function automatic logic [1:0] sg_pair(input logic [7:0] row, input logic [1:0] k);
		logic [7:0] sh;
		sh = row >> {~k, 1'b0};
		return {sh[0], sh[1]};
	endfunction

	function automatic logic [5:0] sg_mask(input logic [7:0] r0, input logic [7:0] r1,
			input logic [7:0] r2, input logic [1:0] k);
		return {sg_pair(r2, k), sg_pair(r1, k), sg_pair(r0, k)};
	endfunction

endpackage

`default_nettype wire

// File: src/sgspr_ram.sv
// generic single-port ram with registered read
`default_nettype none

module sgspr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one access per cycle, read data lands in rdata
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

// File: src/sgspr_dp.sv
// datapath: captured item, sprite position state, screen memory port and result register
`default_nettype none

module sgspr_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sgspr_pkg::cmd_t cmd,
	output sgspr_pkg::sts_t    sts,
	input  wire logic [1:0]    mode,
	input  wire logic [7:0]    x_pixel,
	input  wire logic [7:0]    y_pixel,
	input  wire logic [7:0]    width_pixels,
	input  wire logic [7:0]    row0_bits,
	input  wire logic [7:0]    row1_bits,
	input  wire logic [7:0]    row2_bits,
	input  wire logic [10:0]   cell_address,
	input  wire logic [7:0]    write_data,
	output logic      [7:0]    read_data,
	output logic      [2:0]    cells_changed
);

	import sgspr_pkg::*;

	// captured item
	mode_t              mode_q;
	logic [7:0]         x_q;
	logic [7:0]         w_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [7:0]         r0_q;
	logic [7:0]         r1_q;
	logic [7:0]         r2_q;
	logic [CELL_AW-1:0] addr_q;
	logic [CHAR_W-1:0]  wd_q;

	// sprite state and sequencing
	logic [6:0]         start_column_q;
	logic [CELL_AW-1:0] band_base_q;
	logic [6:0]         cell_count_q;
	logic [1:0]         k_q;
	logic [2:0]         chg_q;
	logic [CELL_AW-1:0] clr_q;

	// result
	logic [7:0]         read_data_q;
	logic [2:0]         cells_changed_q;

	logic [YPROD_W-1:0] y_prod;
	logic [BASE_W-1:0]  base_full;
	logic [5:0]         cell_mask;
	logic [CELL_AW-1:0] cell_addr;

	logic               ram_en;
	logic               ram_we;
	logic [CELL_AW-1:0] ram_addr;
	logic [CHAR_W-1:0]  ram_wdata;
	logic [CHAR_W-1:0]  ram_rdata;

	// divide-by-three reciprocal on the incoming row
	assign y_prod = YPROD_W'(y_pixel) * YPROD_W'(DIV3_RECIP);

	// item capture on transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(mode);
			x_q    <= x_pixel;
			w_q    <= width_pixels;
			quot_q <= y_prod[DIV3_SHIFT +: QUOT_W];
			r0_q   <= row0_bits;
			r1_q   <= row1_bits;
			r2_q   <= row2_bits;
			addr_q <= CELL_AW'(cell_address);
			wd_q   <= write_data;
		end
	end

	// band row from the quotient, wraps with the store size
	assign base_full = BASE_W'(quot_q) * BASE_W'(SCREEN_COLUMNS);

	// sprite position and band progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_column_q <= '0;
			band_base_q    <= '0;
			cell_count_q   <= '0;
		end else if (cmd.begin_wr) begin
			start_column_q <= x_q[7:1];
			cell_count_q   <= w_q[7:1];
			band_base_q    <= base_full[CELL_AW-1:0];
		end else if (cmd.band_adv) begin
			band_base_q <= band_base_q + CELL_AW'(SCREEN_COLUMNS);
		end
	end

	// column counter and changed-cell count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			chg_q <= '0;
		end else if (cmd.capture) begin
			k_q   <= '0;
			chg_q <= '0;
		end else begin
			if (cmd.k_inc) begin
				k_q <= k_q + 2'd1;
			end
			if (cmd.cell_wr) begin
				chg_q <= chg_q + 3'd1;
			end
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + CELL_AW'(1);
		end
	end

	// current cell of the band
	assign cell_mask = sg_mask(r0_q, r1_q, r2_q, k_q);
	assign cell_addr = band_base_q + CELL_AW'(start_column_q) + CELL_AW'(k_q);

	assign sts.clr_last    = (clr_q == CELL_AW'(SCREEN_CELLS - 1));
	assign sts.cell_active = (cell_count_q > {5'b0, k_q}) && (cell_mask != '0);
	assign sts.k_last      = (k_q == 2'(CELLS_PER_BAND - 1));

	// memory port select
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = '0;
		if (cmd.clr_wr) begin
			ram_en   = 1'b1;
			ram_we   = 1'b1;
			ram_addr = clr_q;
		end else if (cmd.begin_wr) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = GFX_MODE_CELL;
			ram_wdata = GFX_MODE_BYTE;
		end else if (cmd.host_wr) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = addr_q;
			ram_wdata = wd_q;
		end else if (cmd.host_rd) begin
			ram_en   = 1'b1;
			ram_addr = addr_q;
		end else if (cmd.cell_rd) begin
			ram_en   = 1'b1;
			ram_addr = cell_addr;
		end else if (cmd.cell_wr) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = cell_addr;
			ram_wdata = sg_encode(sg_decode(ram_rdata) | cell_mask);
		end
	end

	sgspr_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (SCREEN_CELLS)
	) u_screen (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_data_q     <= (mode_q == MODE_HOST_RD) ? ram_rdata : '0;
			cells_changed_q <= chg_q;
		end
	end

	assign read_data     = read_data_q;
	assign cells_changed = cells_changed_q;

endmodule

`default_nettype wire

// File: src/sgspr_ctrl.sv
// controller: clearing sweep, per-item sequencing and output valid
`default_nettype none
`include "semigraphic_sprite_or_macros.svh"

module sgspr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    mode,
	output logic               out_valid,
	input  wire logic          out_stall,
	output sgspr_pkg::cmd_t    cmd,
	input  wire sgspr_pkg::sts_t sts
);

	import sgspr_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (mode_t'(mode))
						MODE_BEGIN:   state_nxt = ST_BEGIN;
						MODE_BAND:    state_nxt = ST_BAND_RD;
						MODE_HOST_WR: state_nxt = ST_HOST_WR;
						MODE_HOST_RD: state_nxt = ST_HOST_RD;
						default:      state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_BEGIN:   state_nxt = ST_DONE;
			ST_HOST_WR: state_nxt = ST_DONE;
			ST_HOST_RD: state_nxt = ST_DONE;
			ST_BAND_RD: begin
				if (sts.cell_active) begin
					state_nxt = ST_BAND_WR;
				end else if (sts.k_last) begin
					state_nxt = ST_BAND_END;
				end
			end
			ST_BAND_WR: begin
				state_nxt = sts.k_last ? ST_BAND_END : ST_BAND_RD;
			end
			ST_BAND_END: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR:   cmd.clr_wr   = 1'b1;
			ST_IDLE:    cmd.capture  = in_valid;
			ST_BEGIN:   cmd.begin_wr = 1'b1;
			ST_HOST_WR: cmd.host_wr  = 1'b1;
			ST_HOST_RD: cmd.host_rd  = 1'b1;
			ST_BAND_RD: begin
				cmd.cell_rd = sts.cell_active;
				cmd.k_inc   = !sts.cell_active && !sts.k_last;
			end
			ST_BAND_WR: begin
				cmd.cell_wr = 1'b1;
				cmd.k_inc   = !sts.k_last;
			end
			ST_BAND_END: cmd.band_adv = 1'b1;
			ST_DONE:     cmd.out_load = out_free;
			default:     cmd = '0;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// checks
	`SGSPR_ASSERT_IMP(a_wr_after_rd, clk, arst_n, cmd.cell_wr, $past(cmd.cell_rd))
	`SGSPR_ASSERT_IMP(a_valid_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_DONE))
	`SGSPR_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, in_valid && !in_stall, state_q != ST_IDLE)
	`SGSPR_ASSERT_NXT(a_done_holds, clk, arst_n, state_q == ST_DONE && out_valid_q && out_stall, state_q == ST_DONE)

endmodule

`default_nettype wire

// File: src/semigraphic_sprite_or.sv
// Begin, host write and host read items pass their own state and then the done state before
// out_valid; a band item runs four column checks plus one screen write per changed cell, then
// band end and done. One item at a time: in_stall holds off new transfers until the item is
// through, and an output stall holds it in the done state; one screen access per cycle on the
// single-port memory. After reset a clearing sweep zeroes the screen memory, transfers held off.
// Reset is asynchronous and active low; it clears the sprite position and the controller.
`default_nettype none

module semigraphic_sprite_or (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  x_pixel,
	input  wire logic [7:0]  y_pixel,
	input  wire logic [7:0]  width_pixels,
	input  wire logic [7:0]  row0_bits,
	input  wire logic [7:0]  row1_bits,
	input  wire logic [7:0]  row2_bits,
	input  wire logic [10:0] cell_address,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  read_data,
	output logic      [2:0]  cells_changed
);

	import sgspr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sgspr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	sgspr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.x_pixel       (x_pixel),
		.y_pixel       (y_pixel),
		.width_pixels  (width_pixels),
		.row0_bits     (row0_bits),
		.row1_bits     (row1_bits),
		.row2_bits     (row2_bits),
		.cell_address  (cell_address),
		.write_data    (write_data),
		.read_data     (read_data),
		.cells_changed (cells_changed)
	);

endmodule

`default_nettype wire
